### hw/rtl/tgql_pkg.sv
// Shared types, constants and helpers for the text glyph quad layout unit.
// Used by tgql_layout, tgql_vertex and text_glyph_quad_layout_unit.
// No dependencies.
package tgql_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int COEF_BITS  = 14;
  localparam int COORD_W    = 34;
  localparam int PROD_W     = 50;
  localparam int SUM_W      = PROD_W + 2;
  localparam int QUOT_W     = SUM_W - COEF_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 200;

  localparam logic [20:0] CHAR_NEWLINE   = 21'h00000A;
  localparam logic [20:0] CHAR_SPACE     = 21'h000020;
  localparam logic [20:0] CHAR_TAB       = 21'h000009;
  localparam logic [20:0] CHAR_BACKSPACE = 21'h000008;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_BITS - 1);
  localparam logic signed [33:0] MAX31 = 34'sh07FFFFFFF;

  localparam logic [63:0] MATRIX_IDENTITY = 64'h4000_0000_0000_4000;
  localparam logic [31:0] COLOR_WHITE     = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_LINEAR    = 3'd0,
    CFG_MATRIX_TRANSLATE = 3'd1,
    CFG_LAYOUT_OFFSET    = 3'd2,
    CFG_SPACING_X        = 3'd3,
    CFG_WRAP_WIDTH       = 3'd4,
    CFG_LINE_HEIGHT      = 3'd5,
    CFG_VERTEX_COLOR     = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  typedef struct packed {
    logic [63:0]        matrix_linear;
    logic [63:0]        matrix_translate;
    logic [63:0]        layout_offset;
    logic signed [15:0] spacing_x;
    logic [23:0]        wrap_width;
    logic [15:0]        line_height;
    logic [31:0]        vertex_color;
  } cfg_t;

  typedef struct packed {
    logic [20:0] char_code;
    logic [15:0] glyph_width;
    logic [15:0] glyph_height;
    logic [15:0] tex_u0;
    logic [15:0] tex_v0;
    logic [15:0] tex_u1;
    logic [15:0] tex_v1;
    logic [7:0]  texture_page;
    logic        first_of_text;
    logic        last_of_text;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] b;
    logic [15:0] tex_u0;
    logic [15:0] tex_v0;
    logic [15:0] tex_u1;
    logic [15:0] tex_v1;
    logic [7:0]  texture_page;
    logic        is_vertex;
    logic [30:0] content_width;
    logic [30:0] content_height;
  } quad_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0] out_u;
    logic [15:0] out_v;
    logic [31:0] out_color;
    logic [7:0]  out_page;
    logic        is_vertex;
    logic        last_of_item;
    logic [30:0] content_width;
    logic [30:0] content_height;
  } vtx_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v[39:31] == 9'h000 || v[39:31] == 9'h1FF) begin
      return v[31:0];
    end else if (v[39]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

### hw/rtl/tgql_layout.sv
// Layout stage: input register, pen and line state, quad register.
// Depends on tgql_pkg.
module tgql_layout (
  input  logic            clk,
  input  logic            rst_n,
  input  tgql_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  tgql_pkg::item_t in_item,
  output logic            quad_valid,
  input  logic            quad_ready,
  output tgql_pkg::quad_t quad
);

  logic            in_valid_r;
  tgql_pkg::item_t item_r;
  logic            quad_valid_r, quad_valid_nxt;
  tgql_pkg::quad_t quad_r, quad_nxt;

  logic signed [31:0] pen_x_r, pen_x_nxt;
  logic signed [31:0] pen_y_r, pen_y_nxt;
  logic [15:0]        clh_r, clh_nxt;
  logic signed [31:0] widest_r, widest_nxt;

  logic signed [31:0] px0, py0, wl0;
  logic [15:0]        clh0;
  logic               is_nl, is_blank, is_glyph, produces, proc, wrap;
  logic signed [33:0] gw34, gh34, sp34, ww34;
  logic signed [31:0] nl_y, blank_x;
  logic signed [31:0] px1, py1, pxw, px2, wlg;
  logic [15:0]        clh1, clh2;
  logic signed [31:0] ox, oy;
  logic signed [33:0] l, r, t, b, ch_sum;
  logic [30:0]        ch;

  always_comb begin
    px0  = item_r.first_of_text ? '0 : pen_x_r;
    py0  = item_r.first_of_text ? '0 : pen_y_r;
    clh0 = item_r.first_of_text ? '0 : clh_r;
    wl0  = item_r.first_of_text ? '0 : widest_r;

    is_nl    = (item_r.char_code == tgql_pkg::CHAR_NEWLINE);
    is_blank = (item_r.char_code == tgql_pkg::CHAR_SPACE) ||
               (item_r.char_code == tgql_pkg::CHAR_TAB) ||
               (item_r.char_code == tgql_pkg::CHAR_BACKSPACE);
    is_glyph = !is_nl && !is_blank;
    produces = is_glyph || item_r.last_of_text;

    gw34 = $signed({18'd0, item_r.glyph_width});
    gh34 = $signed({18'd0, item_r.glyph_height});
    sp34 = 34'(cfg.spacing_x);
    ww34 = $signed({10'd0, cfg.wrap_width});

    nl_y    = tgql_pkg::sat32(40'(34'(py0) - $signed({18'd0, clh0})));
    blank_x = tgql_pkg::sat32(40'(34'(px0) + gw34 + sp34));

    wrap = (cfg.wrap_width != '0) && ((34'(px0) + gw34) > ww34);
    px1  = wrap ? '0 : px0;
    py1  = wrap ? nl_y : py0;
    clh1 = wrap ? '0 : clh0;
    if (cfg.line_height != '0) begin
      clh2 = cfg.line_height;
    end else begin
      clh2 = (item_r.glyph_height > clh1) ? item_r.glyph_height : clh1;
    end

    ox = $signed(cfg.layout_offset[63:32]);
    oy = $signed(cfg.layout_offset[31:0]);
    l  = 34'(px1) - 34'(ox);
    r  = l + gw34;
    t  = 34'(py1) - 34'(oy);
    b  = t - gh34;

    pxw = tgql_pkg::sat32(40'(34'(px1) + gw34));
    wlg = (pxw > wl0) ? pxw : wl0;
    px2 = tgql_pkg::sat32(40'(34'(pxw) + sp34));

    if (is_nl) begin
      pen_x_nxt  = '0;
      pen_y_nxt  = nl_y;
      clh_nxt    = '0;
      widest_nxt = wl0;
    end else if (is_blank) begin
      pen_x_nxt  = blank_x;
      pen_y_nxt  = py0;
      clh_nxt    = clh0;
      widest_nxt = wl0;
    end else begin
      pen_x_nxt  = px2;
      pen_y_nxt  = py1;
      clh_nxt    = clh2;
      widest_nxt = wlg;
    end

    ch_sum = $signed({18'd0, clh_nxt}) - 34'(pen_y_nxt);
    if (ch_sum < 0) begin
      ch = '0;
    end else if (ch_sum > tgql_pkg::MAX31) begin
      ch = tgql_pkg::MAX31[30:0];
    end else begin
      ch = ch_sum[30:0];
    end

    quad_nxt.l              = l;
    quad_nxt.r              = r;
    quad_nxt.t              = t;
    quad_nxt.b              = b;
    quad_nxt.tex_u0         = item_r.tex_u0;
    quad_nxt.tex_v0         = item_r.tex_v0;
    quad_nxt.tex_u1         = item_r.tex_u1;
    quad_nxt.tex_v1         = item_r.tex_v1;
    quad_nxt.texture_page   = item_r.texture_page;
    quad_nxt.is_vertex      = is_glyph;
    quad_nxt.content_width  = widest_nxt[30:0];
    quad_nxt.content_height = ch;

    proc     = in_valid_r && (!produces || !quad_valid_r || quad_ready);
    in_ready = !in_valid_r || proc;

    if (proc && produces) begin
      quad_valid_nxt = 1'b1;
    end else if (quad_ready) begin
      quad_valid_nxt = 1'b0;
    end else begin
      quad_valid_nxt = quad_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      quad_valid_r <= 1'b0;
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      clh_r        <= '0;
      widest_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      quad_valid_r <= quad_valid_nxt;
      if (proc) begin
        pen_x_r  <= pen_x_nxt;
        pen_y_r  <= pen_y_nxt;
        clh_r    <= clh_nxt;
        widest_r <= widest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
    if (proc && produces) begin
      quad_r <= quad_nxt;
    end
  end

  assign quad_valid = quad_valid_r;
  assign quad       = quad_r;

endmodule

### hw/rtl/tgql_vertex.sv
// Vertex stage: corner sequencer, affine multiply register, round/saturate result register.
// Depends on tgql_pkg.
module tgql_vertex (
  input  logic               clk,
  input  logic               rst_n,
  input  tgql_pkg::cfg_t     cfg,
  input  logic               quad_valid,
  output logic               quad_ready,
  input  tgql_pkg::quad_t    quad,
  output logic               out_valid,
  input  logic               out_ready,
  output tgql_pkg::vtx_out_t out_item
);

  tgql_pkg::corner_t cnt_r, cnt_nxt;

  logic adv_out, mul_load, issue, last_corner;
  logic signed [tgql_pkg::COORD_W-1:0] xsel, ysel;
  logic [15:0] usel, vsel;
  logic signed [15:0] m00, m01, m10, m11;
  logic signed [tgql_pkg::PROD_W-1:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt;

  logic mul_valid_r;
  logic signed [tgql_pkg::PROD_W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic [15:0] mu_r, mv_r;
  logic [7:0]  mpage_r;
  logic        mvert_r, mlast_r;
  logic [30:0] mcw_r, mch_r;

  logic signed [tgql_pkg::SUM_W-1:0]  sx, sy;
  logic signed [tgql_pkg::QUOT_W-1:0] qx, qy;
  logic signed [31:0] tx, ty, vx, vy;

  logic               out_valid_r;
  tgql_pkg::vtx_out_t out_r, out_nxt;

  always_comb begin
    adv_out     = !out_valid_r || out_ready;
    mul_load    = !mul_valid_r || adv_out;
    issue       = quad_valid && mul_load;
    last_corner = !quad.is_vertex || (cnt_r == tgql_pkg::CORNER_BL);
    quad_ready  = issue && last_corner;

    if (quad_ready) begin
      cnt_nxt = tgql_pkg::CORNER_TL;
    end else if (issue) begin
      cnt_nxt = tgql_pkg::corner_t'(2'(cnt_r + 2'd1));
    end else begin
      cnt_nxt = cnt_r;
    end

    case (cnt_r)
      tgql_pkg::CORNER_TL: begin
        xsel = quad.l; ysel = quad.t; usel = quad.tex_u0; vsel = quad.tex_v0;
      end
      tgql_pkg::CORNER_TR: begin
        xsel = quad.r; ysel = quad.t; usel = quad.tex_u1; vsel = quad.tex_v0;
      end
      tgql_pkg::CORNER_BR: begin
        xsel = quad.r; ysel = quad.b; usel = quad.tex_u1; vsel = quad.tex_v1;
      end
      tgql_pkg::CORNER_BL: begin
        xsel = quad.l; ysel = quad.b; usel = quad.tex_u0; vsel = quad.tex_v1;
      end
      default: begin
        xsel = quad.l; ysel = quad.t; usel = quad.tex_u0; vsel = quad.tex_v0;
      end
    endcase

    m00 = $signed(cfg.matrix_linear[63:48]);
    m01 = $signed(cfg.matrix_linear[47:32]);
    m10 = $signed(cfg.matrix_linear[31:16]);
    m11 = $signed(cfg.matrix_linear[15:0]);
    pa_nxt = m00 * xsel;
    pb_nxt = m01 * ysel;
    pc_nxt = m10 * xsel;
    pd_nxt = m11 * ysel;

    tx = $signed(cfg.matrix_translate[63:32]);
    ty = $signed(cfg.matrix_translate[31:0]);
    sx = tgql_pkg::SUM_W'(pa_r) + tgql_pkg::SUM_W'(pb_r) + tgql_pkg::ROUND_HALF;
    sy = tgql_pkg::SUM_W'(pc_r) + tgql_pkg::SUM_W'(pd_r) + tgql_pkg::ROUND_HALF;
    qx = $signed(sx[tgql_pkg::SUM_W-1:tgql_pkg::COEF_BITS]);
    qy = $signed(sy[tgql_pkg::SUM_W-1:tgql_pkg::COEF_BITS]);
    vx = tgql_pkg::sat32(40'(qx) + 40'(tx));
    vy = tgql_pkg::sat32(40'(qy) + 40'(ty));

    out_nxt.vertex_x       = mvert_r ? vx : '0;
    out_nxt.vertex_y       = mvert_r ? vy : '0;
    out_nxt.out_u          = mvert_r ? mu_r : '0;
    out_nxt.out_v          = mvert_r ? mv_r : '0;
    out_nxt.out_color      = mvert_r ? cfg.vertex_color : '0;
    out_nxt.out_page       = mvert_r ? mpage_r : '0;
    out_nxt.is_vertex      = mvert_r;
    out_nxt.last_of_item   = mlast_r;
    out_nxt.content_width  = mcw_r;
    out_nxt.content_height = mch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= tgql_pkg::CORNER_TL;
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (mul_load) begin
        mul_valid_r <= issue;
      end
      if (adv_out) begin
        out_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      pc_r    <= pc_nxt;
      pd_r    <= pd_nxt;
      mu_r    <= usel;
      mv_r    <= vsel;
      mpage_r <= quad.texture_page;
      mvert_r <= quad.is_vertex;
      mlast_r <= last_corner;
      mcw_r   <= quad.content_width;
      mch_r   <= quad.content_height;
    end
    if (adv_out && mul_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### hw/rtl/text_glyph_quad_layout_unit.sv
// Text glyph quad layout unit: configuration registers, layout and vertex stages.
// Depends on tgql_pkg, tgql_layout and tgql_vertex.
//
// Usage:
//   in_*  : one character request per transfer. tdata carries the glyph code,
//           metrics, texture rectangle and page; tuser[0] restarts the text,
//           tlast marks its final character.
//   out_* : one result per transfer. A visible glyph gives four vertices
//           (top-left, top-right, bottom-right, bottom-left); a newline or
//           blank gives nothing, or one status result (tuser[0] = 0) when it
//           ends the text. tlast marks the final result of a request.
//   cfg_* : register writes by index; cfg_ready is always high. Write only
//           while no request is in flight.
// A request passes through the input, quad, multiply and result registers
//   before its first result. The multiply stage takes one vertex per cycle
//   unless the result register stalls; a non-final newline or blank gives no quad.
// Reset clears pen, line height, widest line, all valid flags and restores
//   the register defaults. A stalled out_tready holds the result register
//   and backs up through the multiply and quad registers to in_tready.
module text_glyph_quad_layout_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [20:0] char_code, [36:21] glyph_width, [52:37] glyph_height,
  // [68:53] tex_u0, [84:69] tex_v0, [100:85] tex_u1, [116:101] tex_v1,
  // [124:117] texture_page, [127:125] zero
  input  logic [127:0] in_tdata,
  // [0] first_of_text
  input  logic [0:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] vertex_x, [63:32] vertex_y, [79:64] out_u, [95:80] out_v,
  // [127:96] out_color, [135:128] out_page, [166:136] content_width,
  // [197:167] content_height, [199:198] zero
  output logic [199:0] out_tdata,
  // [0] is_vertex
  output logic [0:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  tgql_pkg::cfg_t     cfg_r;
  tgql_pkg::item_t    in_item;
  tgql_pkg::quad_t    quad;
  tgql_pkg::vtx_out_t out_item;
  logic               quad_valid, quad_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.matrix_linear    <= tgql_pkg::MATRIX_IDENTITY;
      cfg_r.matrix_translate <= '0;
      cfg_r.layout_offset    <= '0;
      cfg_r.spacing_x        <= '0;
      cfg_r.wrap_width       <= '0;
      cfg_r.line_height      <= '0;
      cfg_r.vertex_color     <= tgql_pkg::COLOR_WHITE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tgql_pkg::CFG_MATRIX_LINEAR:    cfg_r.matrix_linear    <= cfg_data;
        tgql_pkg::CFG_MATRIX_TRANSLATE: cfg_r.matrix_translate <= cfg_data;
        tgql_pkg::CFG_LAYOUT_OFFSET:    cfg_r.layout_offset    <= cfg_data;
        tgql_pkg::CFG_SPACING_X:        cfg_r.spacing_x        <= $signed(cfg_data[15:0]);
        tgql_pkg::CFG_WRAP_WIDTH:       cfg_r.wrap_width       <= cfg_data[23:0];
        tgql_pkg::CFG_LINE_HEIGHT:      cfg_r.line_height      <= cfg_data[15:0];
        tgql_pkg::CFG_VERTEX_COLOR:     cfg_r.vertex_color     <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.char_code     = in_tdata[20:0];
    in_item.glyph_width   = in_tdata[36:21];
    in_item.glyph_height  = in_tdata[52:37];
    in_item.tex_u0        = in_tdata[68:53];
    in_item.tex_v0        = in_tdata[84:69];
    in_item.tex_u1        = in_tdata[100:85];
    in_item.tex_v1        = in_tdata[116:101];
    in_item.texture_page  = in_tdata[124:117];
    in_item.first_of_text = in_tuser[0];
    in_item.last_of_text  = in_tlast;
  end

  tgql_layout u_layout (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready),
    .quad       (quad)
  );

  tgql_vertex u_vertex (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready),
    .quad       (quad),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (out_item)
  );

  assign out_tdata = {2'b00,
                      out_item.content_height,
                      out_item.content_width,
                      out_item.out_page,
                      out_item.out_color,
                      out_item.out_v,
                      out_item.out_u,
                      out_item.vertex_y,
                      out_item.vertex_x};
  assign out_tuser = out_item.is_vertex;
  assign out_tlast = out_item.last_of_item;

`ifndef NO_ASSERTIONS
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("status result without last flag");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[135:0] == '0)
    else $error("status result carries vertex payload");

  a_quad_release: assert property (@(posedge clk) disable iff (!rst_n)
    quad_ready |-> quad_valid)
    else $error("quad released while empty");
`endif

endmodule
